// File: rtl/aatt_pkg.sv
// Shared constants, codes and derived widths for the averaging threshold trigger.
`default_nettype none

package aatt_pkg;

    // Samples per block average
    localparam int AVERAGE_LENGTH = 5;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 8;
    localparam int REG_W    = 9;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Running sum and sample counter widths
    localparam int SUM_W = $clog2(((1 << LEVEL_W) - 1) * AVERAGE_LENGTH + 1);
    localparam int CNT_W = $clog2(AVERAGE_LENGTH + 1);

    // Reciprocal multiply for floor(sum / AVERAGE_LENGTH), exact over the whole sum range
    localparam int RECIP_SHIFT = SUM_W + $clog2(AVERAGE_LENGTH);
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(AVERAGE_LENGTH) - 64'd1) / 64'(AVERAGE_LENGTH));
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam logic [CNT_W-1:0] AVG_COUNT = CNT_W'(AVERAGE_LENGTH);

    // Trigger modes (code 3 is reserved)
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWITCH = 2'd2;

    // Item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_EVAL   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_REGISTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_REGISTER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_VALUE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_REGISTER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_VALUE      = 3'd6;

endpackage

`default_nettype wire

// File: rtl/adc_average_threshold_trigger_unit.sv
// Top level of the averaging threshold trigger for one analog channel.
`default_nettype none

// One analog trigger channel. Sample items (tuser = 0) carry a 12-bit converter value; its
// top 8 bits are summed, and every AVERAGE_LENGTH samples the floor of the block average
// becomes the current level. Evaluate items (tuser = 1) compare the current level with the
// level recorded at the last effective evaluation and, in map or switch mode, may produce one
// register write item on the master side. Each item is processed in the
// cycle it is accepted and any result lands in the output register, so one item per clock
// is sustained while the master side keeps up. The slave side stalls only while a result sits
// in the output register and the master side is not ready. Configuration writes take effect
// at the next edge and are to be made while no item is in flight.
module adc_average_threshold_trigger_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [aatt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [aatt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Slave side
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [15:0]                   i_s_axis_tdata,  // [11:0] sample
    input  wire logic                          i_s_axis_tuser,  // [0] command
    // Master side
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [23:0]                        o_m_axis_tdata   // [8:0] write_register, [16:9] write_value
);
    import aatt_pkg::*;

    // Configuration registers
    logic [MODE_W-1:0]  r_trigger_mode;
    logic [REG_W-1:0]   r_map_register;
    logic [LEVEL_W-1:0] r_threshold_level;
    logic [REG_W-1:0]   r_rise_register;
    logic [LEVEL_W-1:0] r_rise_value;
    logic [REG_W-1:0]   r_fall_register;
    logic [LEVEL_W-1:0] r_fall_value;

    // Channel state
    logic [SUM_W-1:0]   r_sample_sum,   n_sample_sum;
    logic [CNT_W-1:0]   r_sample_count, n_sample_count;
    logic [SUM_W-1:0]   r_block_sum,    n_block_sum;
    logic [LEVEL_W-1:0] r_prev_level,   n_prev_level;

    // Output register
    logic               r_out_valid,    n_out_valid;
    logic [REG_W-1:0]   r_out_register, n_out_register;
    logic [LEVEL_W-1:0] r_out_value,    n_out_value;

    logic               w_accept;
    logic               w_command;
    logic [LEVEL_W-1:0] w_sample8;
    logic [SUM_W-1:0]   w_sum_next;
    logic [CNT_W-1:0]   w_count_next;
    logic [PROD_W-1:0]  w_prod;
    logic [LEVEL_W-1:0] w_cur_level;
    logic               w_rise;
    logic               w_fall;

    // Take an item whenever the output register is free or being emptied
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_command       = i_s_axis_tuser;
    assign w_sample8       = i_s_axis_tdata[SAMPLE_W-1 -: LEVEL_W];

    assign w_sum_next   = r_sample_sum + SUM_W'(w_sample8);
    assign w_count_next = r_sample_count + CNT_W'(1);

    // Current level: floor(block sum / AVERAGE_LENGTH) by reciprocal multiply
    assign w_prod      = PROD_W'(r_block_sum) * PROD_W'(RECIP_MULT);
    assign w_cur_level = w_prod[RECIP_SHIFT +: LEVEL_W];

    // Strict threshold crossings
    assign w_rise = (w_cur_level > r_threshold_level) && (r_prev_level < r_threshold_level);
    assign w_fall = (w_cur_level < r_threshold_level) && (r_prev_level > r_threshold_level);

    // Next state and result
    always_comb begin
        n_sample_sum   = r_sample_sum;
        n_sample_count = r_sample_count;
        n_block_sum    = r_block_sum;
        n_prev_level   = r_prev_level;
        n_out_valid    = r_out_valid && !i_m_axis_tready;
        n_out_register = r_out_register;
        n_out_value    = r_out_value;

        if (w_accept) begin
            if (w_command == CMD_SAMPLE) begin
                // Gather a sample; close the block when it is full
                if (w_count_next >= AVG_COUNT) begin
                    n_block_sum    = w_sum_next;
                    n_sample_sum   = '0;
                    n_sample_count = '0;
                end else begin
                    n_sample_sum   = w_sum_next;
                    n_sample_count = w_count_next;
                end
            end else if (r_trigger_mode != MODE_NONE && w_cur_level != r_prev_level) begin
                // Evaluate and record the level
                n_prev_level = w_cur_level;
                case (r_trigger_mode)
                    MODE_MAP: begin
                        n_out_valid    = 1'b1;
                        n_out_register = r_map_register;
                        n_out_value    = w_cur_level;
                    end
                    MODE_SWITCH: begin
                        if (w_rise) begin
                            n_out_valid    = 1'b1;
                            n_out_register = r_rise_register;
                            n_out_value    = r_rise_value;
                        end else if (w_fall) begin
                            n_out_valid    = 1'b1;
                            n_out_register = r_fall_register;
                            n_out_value    = r_fall_value;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Hold configuration, state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_mode    <= MODE_NONE;
            r_map_register    <= '0;
            r_threshold_level <= '0;
            r_rise_register   <= '0;
            r_rise_value      <= '0;
            r_fall_register   <= '0;
            r_fall_value      <= '0;
            r_sample_sum      <= '0;
            r_sample_count    <= '0;
            r_block_sum       <= '0;
            r_prev_level      <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TRIGGER_MODE:    r_trigger_mode    <= i_cfg_wdata[MODE_W-1:0];
                    CFG_MAP_REGISTER:    r_map_register    <= i_cfg_wdata[REG_W-1:0];
                    CFG_THRESHOLD_LEVEL: r_threshold_level <= i_cfg_wdata[LEVEL_W-1:0];
                    CFG_RISE_REGISTER:   r_rise_register   <= i_cfg_wdata[REG_W-1:0];
                    CFG_RISE_VALUE:      r_rise_value      <= i_cfg_wdata[LEVEL_W-1:0];
                    CFG_FALL_REGISTER:   r_fall_register   <= i_cfg_wdata[REG_W-1:0];
                    CFG_FALL_VALUE:      r_fall_value      <= i_cfg_wdata[LEVEL_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_sample_sum   <= n_sample_sum;
            r_sample_count <= n_sample_count;
            r_block_sum    <= n_block_sum;
            r_prev_level   <= n_prev_level;
            r_out_valid    <= n_out_valid;
        end
    end

    // Payload of the output register
    always_ff @(posedge i_clk) begin
        r_out_register <= n_out_register;
        r_out_value    <= n_out_value;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_value, r_out_register};

    // A sample item never produces a result
    a_sample_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_command == CMD_SAMPLE) |=> !o_m_axis_tvalid)
        else $error("result produced by a sample item");

    // The counter never reaches the block length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sample_count < AVG_COUNT)
        else $error("sample counter out of range");

    // A held result blocks the slave side
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("item accepted while result stalled");

    // An unchanged level leaves the recorded level alone
    a_prev_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_command == CMD_EVAL) && (w_cur_level == r_prev_level)
        |=> $stable(r_prev_level))
        else $error("recorded level changed on an unchanged evaluation");

endmodule

`default_nettype wire

// File: tb/tb_adc_average_threshold_trigger_unit.sv
// Self-checking testbench for the averaging threshold trigger unit.
`default_nettype none

module tb_adc_average_threshold_trigger_unit;
    import aatt_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 3'd7;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 100;

    // One register write produced by an evaluation
    typedef struct packed {
        logic [REG_W-1:0]   wreg;
        logic [LEVEL_W-1:0] wval;
    } reg_write_t;

    // Tracks averaging and trigger state and holds the writes still owed by the block
    class trigger_board;
        logic [MODE_W-1:0]  mode      = '0;
        logic [REG_W-1:0]   map_reg   = '0;
        logic [LEVEL_W-1:0] threshold = '0;
        logic [REG_W-1:0]   rise_reg  = '0;
        logic [LEVEL_W-1:0] rise_val  = '0;
        logic [REG_W-1:0]   fall_reg  = '0;
        logic [LEVEL_W-1:0] fall_val  = '0;
        logic [SUM_W-1:0]   sum       = '0;
        logic [CNT_W-1:0]   count     = '0;
        logic [LEVEL_W-1:0] level     = '0;
        logic [LEVEL_W-1:0] recorded  = '0;
        reg_write_t writes_due[$];
        int errors  = 0;
        int items   = 0;
        int evals   = 0;
        int checked = 0;

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TRIGGER_MODE:    mode      = val[MODE_W-1:0];
                CFG_MAP_REGISTER:    map_reg   = val[REG_W-1:0];
                CFG_THRESHOLD_LEVEL: threshold = val[LEVEL_W-1:0];
                CFG_RISE_REGISTER:   rise_reg  = val[REG_W-1:0];
                CFG_RISE_VALUE:      rise_val  = val[LEVEL_W-1:0];
                CFG_FALL_REGISTER:   fall_reg  = val[REG_W-1:0];
                CFG_FALL_VALUE:      fall_val  = val[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the averaging or the trigger for one accepted item
        function void note_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
            items++;
            if (cmd == CMD_SAMPLE) begin
                sum   = sum + SUM_W'(smp[SAMPLE_W-1:SAMPLE_W-LEVEL_W]);
                count = count + 1'b1;
                if (count >= AVG_COUNT) begin
                    level = LEVEL_W'(sum / AVERAGE_LENGTH);
                    sum   = '0;
                    count = '0;
                end
                return;
            end
            evals++;
            // unchanged level or mode none: leave the recorded level alone
            if (mode == MODE_NONE || level == recorded)
                return;
            if (mode == MODE_MAP) begin
                writes_due.push_back('{map_reg, level});
            end else if (mode == MODE_SWITCH) begin
                if (level > threshold && recorded < threshold)
                    writes_due.push_back('{rise_reg, rise_val});
                else if (level < threshold && recorded > threshold)
                    writes_due.push_back('{fall_reg, fall_val});
            end
            recorded = level;
        endfunction

        task check_result(input logic [REG_W-1:0] wreg, input logic [LEVEL_W-1:0] wval);
            reg_write_t want;
            if (writes_due.size() == 0) begin
                report($sformatf("unexpected write reg %0d value %0d", wreg, wval));
                return;
            end
            want = writes_due.pop_front();
            checked++;
            if (wreg !== want.wreg)
                report($sformatf("write %0d: register %0d, wanted %0d", checked, wreg, want.wreg));
            if (wval !== want.wval)
                report($sformatf("write %0d: value %0d, wanted %0d", checked, wval, want.wval));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data  = '0;
    logic        s_user  = 1'b0;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire [23:0]  m_data;

    trigger_board board = new;
    bit no_idle = 1'b0;
    int cycle_count = 0;
    int settings = 0;
    logic [MODE_W-1:0] phase_modes [PHASES] = '{MODE_MAP, MODE_SWITCH, MODE_SWITCH, MODE_NONE,
        MODE_SWITCH, MODE_MAP, MODE_RESERVED, MODE_SWITCH, MODE_MAP, MODE_SWITCH};

    adc_average_threshold_trigger_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    // Offer one item and hold it until accepted; keep valid high into a back-to-back item
    task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0, smp};
        s_user  <= cmd;
        @(posedge clk);
        while (s_ready !== 1'b1) @(posedge clk);
        board.note_item(cmd, smp);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    // Write every register, plus one unused index that must be ignored
    task automatic configure(input logic [MODE_W-1:0] mode, input logic [REG_W-1:0] map_reg,
                             input logic [LEVEL_W-1:0] thr, input logic [REG_W-1:0] rreg,
                             input logic [LEVEL_W-1:0] rval, input logic [REG_W-1:0] freg,
                             input logic [LEVEL_W-1:0] fval);
        write_reg(CFG_TRIGGER_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_MAP_REGISTER, map_reg);
        write_reg(CFG_THRESHOLD_LEVEL, CFG_DATA_W'(thr));
        write_reg(CFG_RISE_REGISTER, rreg);
        write_reg(CFG_RISE_VALUE, CFG_DATA_W'(rval));
        write_reg(CFG_FALL_REGISTER, freg);
        write_reg(CFG_FALL_VALUE, CFG_DATA_W'(fval));
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // Drop valid, drain the owed writes and let the output register empty
    task automatic finish_phase();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (board.writes_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly a full block of samples aimed at one level and an evaluation; some noise
    task automatic send_group(input logic [LEVEL_W-1:0] thr);
        int kind;
        int lvl;
        int top;
        kind = $urandom_range(0, 11);
        if (kind == 10) begin
            send_item(1'($urandom), SAMPLE_W'($urandom));
            return;
        end
        if (kind <= 4)
            lvl = int'(thr) + int'($urandom_range(0, 6)) - 3;
        else if (kind == 9)
            lvl = ($urandom_range(0, 1) != 0) ? 255 : 0;
        else
            lvl = $urandom_range(0, 255);
        repeat ((kind == 11) ? $urandom_range(1, 4) : AVERAGE_LENGTH) begin
            top = lvl;
            if (kind == 8)
                top = lvl + int'($urandom_range(0, 4)) - 2;
            top = (top < 0) ? 0 : (top > 255) ? 255 : top;
            send_item(CMD_SAMPLE, {8'(top), 4'($urandom)});
        end
        send_item(CMD_EVAL, SAMPLE_W'($urandom));
    endtask

    // Accept results with random stalls and check each one
    initial begin : result_sink
        int gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (m_valid !== 1'b1) @(posedge clk);
            board.check_result(m_data[8:0], m_data[16:9]);
        end
    end

    initial begin : stimulus
        int phase_end;
        logic [LEVEL_W-1:0] thr;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mode none: a changed level is ignored and not recorded
        configure(MODE_NONE, '0, '0, '0, '0, '0, '0);
        repeat (AVERAGE_LENGTH) send_item(CMD_SAMPLE, 12'hFFF);
        send_item(CMD_EVAL, 12'h000);
        finish_phase();

        // map mode: first evaluation writes the level, a repeat stays silent
        configure(MODE_MAP, 9'h1FF, '0, '0, '0, '0, '0);
        send_item(CMD_EVAL, 12'hFFF);
        send_item(CMD_EVAL, 12'h000);
        finish_phase();

        // switch mode: fall below, land on the threshold, then leave it upwards
        configure(MODE_SWITCH, '0, 8'd128, 9'h155, 8'hA5, 9'h0AA, 8'h5A);
        repeat (AVERAGE_LENGTH) send_item(CMD_SAMPLE, 12'h00F);
        send_item(CMD_EVAL, 12'h000);
        repeat (AVERAGE_LENGTH) send_item(CMD_SAMPLE, 12'h800);
        send_item(CMD_EVAL, 12'h000);
        repeat (AVERAGE_LENGTH) send_item(CMD_SAMPLE, 12'hFF0);
        send_item(CMD_EVAL, 12'hFFF);
        finish_phase();

        // random phases, each under its own setting
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                configure(phase_modes[p], 9'h1FF, 8'hFF, 9'h1FF, 8'hFF, 9'h1FF, 8'hFF);
            end else if (p == 1) begin
                configure(phase_modes[p], '0, '0, '0, '0, '0, '0);
            end else begin
                thr = LEVEL_W'($urandom_range(8, 247));
                configure(phase_modes[p], REG_W'($urandom), thr, REG_W'($urandom),
                          LEVEL_W'($urandom), REG_W'($urandom), LEVEL_W'($urandom));
            end
            no_idle = (p % 3 == 2);
            phase_end = board.items + PHASE_ITEMS;
            while (board.items < phase_end)
                send_group(board.threshold);
            finish_phase();
        end
        no_idle = 1'b0;

        if (board.writes_due.size() != 0)
            board.report($sformatf("%0d writes never arrived", board.writes_due.size()));
        $display("summary: %0d items (%0d evaluations), %0d register writes checked, %0d settings",
                 board.items, board.evals, board.checked, settings);
        $display("summary: all trigger modes incl. reserved, extreme registers, gaps 0-11 both sides");
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
